[hw/rtl/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants of the shutter pulse timer.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int CMD_DEPTH      = 2;
    localparam int RES_DEPTH      = 2;

    localparam int FRAC_W    = 20;
    localparam int DIV_STEPS = FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [FRAC_W-1:0] FRAC_SCALE = FRAC_W'(1000000);

    localparam logic [1:0] CH_FIRST = 2'd0;
    localparam logic [1:0] CH_LAST  = 2'd2;

    localparam logic LVL_START = 1'b0;
    localparam logic LVL_END   = 1'b1;

    localparam logic KIND_SPEED   = 1'b0;
    localparam logic KIND_CURTAIN = 1'b1;

    typedef struct packed {
        logic [1:0]  channel;
        logic [31:0] width;
        logic        zero;
        logic        big;
        logic        curtain;
        logic [31:0] lead;
        logic [31:0] trail;
    } t_cmd;

    typedef struct packed {
        logic              kind;
        logic [1:0]        source;
        logic [31:0]       width_us;
        logic [FRAC_W-1:0] fraction_denominator;
        logic [31:0]       leading_travel_us;
        logic [31:0]       trailing_travel_us;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/shutter_pulse_timer.sv]
// ----------------------------------------------------------------------------
// shutter_pulse_timer
// Pulse-width capture on three light-beam detectors with curtain travel.
// ----------------------------------------------------------------------------
// Edge events go in through a push/full port and results come out through an
// empty/pop port. A low edge, or an edge on channel 3, is absorbed and gives
// no result. A high edge gives a speed result and, when it completes the
// curtain pair of channels 0 and 2, a curtain result after it with last set.
// A high edge whose width lies between 1 and 1000000 holds the result engine
// while it takes the command, runs its one-bit-per-cycle divider for
// 1000000/width and hands over the speed result; a zero or larger width
// skips the divider. A curtain result holds the engine in a further state.
// A two-entry command queue lets further edges be accepted while the divider
// runs, and a two-entry result queue holds finished results.
`default_nettype none

module shutter_pulse_timer
    import spt_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [1:0]        i_channel,
    input  wire logic              i_level,
    input  wire logic [31:0]       i_time_us,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   o_kind,
    output logic [1:0]             o_source,
    output logic [31:0]            o_width_us,
    output logic [FRAC_W-1:0]      o_fraction_denominator,
    output logic [31:0]            o_leading_travel_us,
    output logic [31:0]            o_trailing_travel_us,
    output logic                   o_last
);

    t_cmd    cmd_in;
    t_cmd    cmd_out;
    logic    cmd_push;
    logic    cmd_full;
    logic    cmd_pop;
    logic    cmd_empty;
    t_result res_in;
    t_result res_out;
    logic    res_push;
    logic    res_full;

    spt_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_channel  (i_channel),
        .i_level    (i_level),
        .i_time_us  (i_time_us),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    spt_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    spt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    spt_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_kind                 = res_out.kind;
    assign o_source               = res_out.source;
    assign o_width_us             = res_out.width_us;
    assign o_fraction_denominator = res_out.fraction_denominator;
    assign o_leading_travel_us    = res_out.leading_travel_us;
    assign o_trailing_travel_us   = res_out.trailing_travel_us;
    assign o_last                 = res_out.last;

endmodule

`default_nettype wire

[hw/rtl/spt_fifo.sv]
// ----------------------------------------------------------------------------
// spt_fifo
// Small register queue, push/full on one side and pop/empty on the other.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/spt_front.sv]
// ----------------------------------------------------------------------------
// spt_front
// Edge intake: keeps start/end times and curtain flags, emits work commands.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_front
    import spt_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_channel,
    input  wire logic        i_level,
    input  wire logic [31:0] i_time_us,
    output logic             o_cmd_push,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_full
);

    localparam int TW = TIME_WIDTH;

    logic [TW-1:0] r_start [3];
    logic [TW-1:0] r_end   [3];
    logic [1:0]    r_flag;

    logic [TW-1:0] t;
    logic [TW-1:0] w;
    logic [TW-1:0] end_a;
    logic [TW-1:0] end_c;
    logic [TW-1:0] lead;
    logic [TW-1:0] trail;
    logic [1:0]    n_flag;
    logic [1:0]    ch_idx;
    logic          take;
    logic          valid_ch;
    logic          curtain;

    assign o_full   = i_cmd_full;
    assign take     = i_push && !i_cmd_full;
    assign valid_ch = (i_channel <= CH_LAST);
    assign ch_idx   = valid_ch ? i_channel : CH_FIRST;
    assign t        = TW'(i_time_us);
    assign w        = t - r_start[ch_idx];

    assign end_a = (i_channel == CH_FIRST) ? t : r_end[0];
    assign end_c = (i_channel == CH_LAST)  ? t : r_end[2];
    assign lead  = (r_start[0] > r_start[2]) ? r_start[0] - r_start[2]
                                             : r_start[2] - r_start[0];
    assign trail = (end_a > end_c) ? end_a - end_c : end_c - end_a;

    always_comb begin
        n_flag = r_flag;
        if (i_channel == CH_FIRST) begin
            n_flag[0] = i_level;
        end
        if (i_channel == CH_LAST) begin
            n_flag[1] = i_level;
        end
    end

    assign curtain = n_flag[0] && n_flag[1];

    assign o_cmd_push    = take && valid_ch && (i_level == LVL_END);
    assign o_cmd.channel = i_channel;
    assign o_cmd.width   = 32'(w);
    assign o_cmd.zero    = (w == '0);
    assign o_cmd.big     = (64'(w) > 64'(FRAC_SCALE));
    assign o_cmd.curtain = curtain;
    assign o_cmd.lead    = 32'(lead);
    assign o_cmd.trail   = 32'(trail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '0;
            for (int i = 0; i < 3; i++) begin
                r_start[i] <= '0;
                r_end[i]   <= '0;
            end
        end else if (take && valid_ch) begin
            if (i_level == LVL_START) begin
                r_start[i_channel] <= t;
                r_flag             <= n_flag;
            end else begin
                r_end[i_channel] <= t;
                r_flag           <= curtain ? 2'b00 : n_flag;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/spt_back.sv]
// ----------------------------------------------------------------------------
// spt_back
// Result engine: bit-serial 1000000/width divider and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_back
    import spt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cmd_empty,
    input  wire t_cmd   i_cmd,
    output logic        o_cmd_pop,
    input  wire logic   i_res_full,
    output logic        o_res_push,
    output t_result     o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SPEED,
        S_CURT
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [FRAC_W-1:0]     r_num;
    logic [FRAC_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0]  r_cnt;

    logic [FRAC_W:0]       trial;
    logic [FRAC_W:0]       divisor;
    logic                  ge;

    assign divisor = {1'b0, r_cmd.width[FRAC_W-1:0]};
    assign trial   = {r_rem, r_num[FRAC_W-1]};
    assign ge      = (trial >= divisor);

    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;

    always_comb begin
        o_res = '0;
        case (r_state)
            S_SPEED: begin
                o_res.kind                 = KIND_SPEED;
                o_res.source               = r_cmd.channel;
                o_res.width_us             = r_cmd.width;
                o_res.fraction_denominator = r_num;
                o_res.last                 = !r_cmd.curtain;
            end
            S_CURT: begin
                o_res.kind               = KIND_CURTAIN;
                o_res.leading_travel_us  = r_cmd.lead;
                o_res.trailing_travel_us = r_cmd.trail;
                o_res.last               = 1'b1;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    assign o_res_push = ((r_state == S_SPEED) || (r_state == S_CURT)) && !i_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd <= i_cmd;
                        r_rem <= '0;
                        r_cnt <= '0;
                        if (i_cmd.zero) begin
                            r_num   <= FRAC_SCALE;
                            r_state <= S_SPEED;
                        end else if (i_cmd.big) begin
                            r_num   <= '0;
                            r_state <= S_SPEED;
                        end else begin
                            r_num   <= FRAC_SCALE;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? FRAC_W'(trial - divisor) : FRAC_W'(trial);
                    r_num <= {r_num[FRAC_W-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_SPEED;
                    end
                end
                S_SPEED: begin
                    if (!i_res_full) begin
                        r_state <= r_cmd.curtain ? S_CURT : S_IDLE;
                    end
                end
                S_CURT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/spt_checker.sv]
// ----------------------------------------------------------------------------
// spt_port_props
// Port-level checks of the shutter pulse timer result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_port_props
    import spt_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              push,
    input wire logic              full,
    input wire logic [1:0]        i_channel,
    input wire logic              i_level,
    input wire logic [31:0]       i_time_us,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic              o_kind,
    input wire logic [1:0]        o_source,
    input wire logic [31:0]       o_width_us,
    input wire logic [FRAC_W-1:0] o_fraction_denominator,
    input wire logic [31:0]       o_leading_travel_us,
    input wire logic [31:0]       o_trailing_travel_us,
    input wire logic              o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_width_us)
                              && $stable(o_last)))
        else $error("waiting result changed");

    a_curtain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_CURTAIN) |-> (o_last && o_source == 2'd0
            && o_width_us == 32'd0 && o_fraction_denominator == '0))
        else $error("bad curtain result");

    a_speed_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_SPEED) |-> (o_leading_travel_us == 32'd0
            && o_trailing_travel_us == 32'd0 && o_source != 2'd3))
        else $error("bad speed result");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_SPEED) |->
            (o_fraction_denominator <= FRAC_SCALE
             && (o_width_us != 32'd1 || o_fraction_denominator == FRAC_SCALE)))
        else $error("fraction out of range");

    a_speed_before_curtain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_kind == KIND_SPEED && !o_last) |=>
            (empty || o_kind == KIND_CURTAIN))
        else $error("curtain result missing after non-final speed result");

endmodule

bind shutter_pulse_timer spt_port_props u_spt_port_props (.*);

`default_nettype wire
